// ===== rtl/core/isoag_pkg.sv =====
// ----------------------------------------------------------------------------
// isoag_pkg: shared types, constants and tables of the scan-order address gen
// Holds the register codes, the Hilbert orientation type with its quadrant
// and child tables, and the control bundle that rides along the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isoag_pkg;

   // Default largest log2 of the image side
   localparam int MAX_LOG_SIZE_DEF = 10;

   // Hilbert levels resolved per pipeline stage
   localparam int LEVELS_PER_STAGE = 4;

   // Field widths of the stream payloads
   localparam int IDX_W       = 20;
   localparam int ADDR_W      = 20;
   localparam int COORD_W     = 10;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;

   // Effective log size, wide enough for sizes up to 16
   localparam int LG_W = 5;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_SCAN_MODE = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_LOG_SIZE  = 1'b1;

   // Scan modes (code 3 acts as raster)
   localparam logic [1:0] MODE_RASTER  = 2'd0;
   localparam logic [1:0] MODE_QUAD    = 2'd1;
   localparam logic [1:0] MODE_HILBERT = 2'd2;

   typedef enum logic [1:0] {
      OR_RIGHT = 2'd0,
      OR_LEFT  = 2'd1,
      OR_UP    = 2'd2,
      OR_DOWN  = 2'd3
   } orient_type;

   typedef struct packed {
      logic [1:0]      mode;
      logic [LG_W-1:0] lg;
      logic            last;
   } ctl_type;

   // Column bit of quadrant q under orientation o
   function automatic logic hil_qx(input orient_type o, input logic [1:0] q);
      logic [3:0] row;
      unique case (o)
         OR_RIGHT: row = 4'b0110;
         OR_LEFT:  row = 4'b1001;
         OR_UP:    row = 4'b0011;
         OR_DOWN:  row = 4'b1100;
      endcase
      return row[q];
   endfunction

   // Row bit of quadrant q under orientation o
   function automatic logic hil_qy(input orient_type o, input logic [1:0] q);
      logic [3:0] row;
      unique case (o)
         OR_RIGHT: row = 4'b1100;
         OR_LEFT:  row = 4'b0011;
         OR_UP:    row = 4'b1001;
         OR_DOWN:  row = 4'b0110;
      endcase
      return row[q];
   endfunction

   // Orientation of the child in quadrant q
   function automatic orient_type hil_child(input orient_type o, input logic [1:0] q);
      orient_type c;
      unique case (o)
         OR_RIGHT: begin
            unique case (q)
               2'd0:    c = OR_DOWN;
               2'd3:    c = OR_UP;
               default: c = OR_RIGHT;
            endcase
         end
         OR_LEFT: begin
            unique case (q)
               2'd0:    c = OR_UP;
               2'd3:    c = OR_DOWN;
               default: c = OR_LEFT;
            endcase
         end
         OR_UP: begin
            unique case (q)
               2'd0:    c = OR_LEFT;
               2'd3:    c = OR_RIGHT;
               default: c = OR_UP;
            endcase
         end
         OR_DOWN: begin
            unique case (q)
               2'd0:    c = OR_RIGHT;
               2'd3:    c = OR_LEFT;
               default: c = OR_DOWN;
            endcase
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/isoag_curve_stage.sv =====
// ----------------------------------------------------------------------------
// isoag_curve_stage: one registered stage of the curve walk
// Resolves a group of index digits, from the highest level down, into
// column and row bits for Z-order and Hilbert scans, and carries the
// orientation on to the next stage. Raster transactions pass unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isoag_curve_stage #(
   parameter int MAX_LOG_SIZE = isoag_pkg::MAX_LOG_SIZE_DEF,
   parameter int HI_LEVEL     = isoag_pkg::MAX_LOG_SIZE_DEF - 1,
   parameter int NUM_LEVELS   = isoag_pkg::LEVELS_PER_STAGE
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [2*MAX_LOG_SIZE-1:0]     in_idx,
   input  wire logic [MAX_LOG_SIZE-1:0]       in_x,
   input  wire logic [MAX_LOG_SIZE-1:0]       in_y,
   input  wire isoag_pkg::orient_type         in_ori,
   input  wire isoag_pkg::ctl_type            in_ctl,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [2*MAX_LOG_SIZE-1:0]          out_idx,
   output logic [MAX_LOG_SIZE-1:0]            out_x,
   output logic [MAX_LOG_SIZE-1:0]            out_y,
   output isoag_pkg::orient_type              out_ori,
   output isoag_pkg::ctl_type                 out_ctl
);

   logic                        valid_ff, valid_in;
   logic [2*MAX_LOG_SIZE-1:0]   idx_ff;
   logic [MAX_LOG_SIZE-1:0]     x_ff, x_in;
   logic [MAX_LOG_SIZE-1:0]     y_ff, y_in;
   isoag_pkg::orient_type       ori_ff, ori_in;
   isoag_pkg::ctl_type          ctl_ff;

   // Walk the digits of this stage, top level first
   always_comb begin
      logic [1:0] q;
      x_in   = in_x;
      y_in   = in_y;
      ori_in = in_ori;
      for (int j = 0; j < NUM_LEVELS; j++) begin
         q = in_idx[2*(HI_LEVEL-j) +: 2];
         unique case (in_ctl.mode)
            isoag_pkg::MODE_QUAD: begin
               x_in[HI_LEVEL-j] = q[0];
               y_in[HI_LEVEL-j] = q[1];
            end
            isoag_pkg::MODE_HILBERT: begin
               x_in[HI_LEVEL-j] = isoag_pkg::hil_qx(ori_in, q);
               y_in[HI_LEVEL-j] = isoag_pkg::hil_qy(ori_in, q);
            end
            default: begin
               x_in = in_x;
               y_in = in_y;
            end
         endcase
         ori_in = isoag_pkg::hil_child(ori_in, q);
      end
   end

   // Take a new transaction when empty or when the next stage drains this one
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload only on an accepted transaction
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         idx_ff <= in_idx;
         x_ff   <= x_in;
         y_ff   <= y_in;
         ori_ff <= ori_in;
         ctl_ff <= in_ctl;
      end
   end

   assign out_valid = valid_ff;
   assign out_idx   = idx_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_ori   = ori_ff;
   assign out_ctl   = ctl_ff;

endmodule

`default_nettype wire

// ===== rtl/core/image_scan_order_address_gen.sv =====
// ----------------------------------------------------------------------------
// image_scan_order_address_gen: scan-order to source pixel address mapper
// Maps a position in raster, Z-order or Hilbert scan of a square
// power-of-two image to the row-major source address and its coordinates.
// ----------------------------------------------------------------------------
// The block takes one index transaction per clock unless the result stream
// stalls, and returns one result per index, in order. The pipe holds an
// input stage that masks the index and builds the raster answer, one curve
// stage for every four levels of the Hilbert/Z walk, and the output register
// that forms y*side+x. Index bits at and above 2*log_size are ignored;
// rsp_tlast marks the final position of the image. Write scan_mode and
// log_size only while no transaction is in flight. There is no memory and no
// start-up sweep.
`timescale 1ns / 1ps
`default_nettype none

module image_scan_order_address_gen #(
   parameter int MAX_LOG_SIZE = isoag_pkg::MAX_LOG_SIZE_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Index stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [isoag_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [19:0] out_index
   // Result stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [isoag_pkg::RSP_TDATA_W-1:0]        rsp_tdata,  // [19:0] src_address,
                                                                // [29:20] src_x,
                                                                // [39:30] src_y
   output logic                                     rsp_tlast,  // is_last
   // Register port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [isoag_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [isoag_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [isoag_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                     csr_pready
);

   localparam int CNT_W     = 2 * MAX_LOG_SIZE;
   localparam int LPS       = isoag_pkg::LEVELS_PER_STAGE;
   localparam int NSTG      = (MAX_LOG_SIZE + LPS - 1) / LPS;
   localparam int IN_EXT_W  = (CNT_W > isoag_pkg::IDX_W) ? CNT_W : isoag_pkg::IDX_W;
   localparam int ADR_EXT_W = (CNT_W > isoag_pkg::ADDR_W) ? CNT_W : isoag_pkg::ADDR_W;
   localparam int CRD_EXT_W = (MAX_LOG_SIZE > isoag_pkg::COORD_W) ?
                              MAX_LOG_SIZE : isoag_pkg::COORD_W;
   localparam int LG_W      = isoag_pkg::LG_W;
   // Zero digits above log_size alternate right/down without moving, so a
   // fixed start at the top level reaches the right start orientation.
   localparam isoag_pkg::orient_type START_ORI =
      (MAX_LOG_SIZE % 2 == 0) ? isoag_pkg::OR_DOWN : isoag_pkg::OR_RIGHT;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [1:0]                      scan_mode_ff;
   logic [3:0]                      log_size_ff;
   logic                            csr_write;
   logic [isoag_pkg::REG_IDX_W-1:0] csr_reg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_paddr[isoag_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_mode_ff <= isoag_pkg::MODE_RASTER;
         log_size_ff  <= 4'd10;
      end else if (csr_write) begin
         unique case (csr_reg)
            isoag_pkg::REG_SCAN_MODE: scan_mode_ff <= csr_pwdata[1:0];
            isoag_pkg::REG_LOG_SIZE:  log_size_ff  <= csr_pwdata[3:0];
         endcase
      end
   end

   // Return the addressed register
   always_comb begin
      unique case (csr_reg)
         isoag_pkg::REG_SCAN_MODE: csr_prdata = isoag_pkg::CSR_DATA_W'(scan_mode_ff);
         isoag_pkg::REG_LOG_SIZE:  csr_prdata = isoag_pkg::CSR_DATA_W'(log_size_ff);
      endcase
   end

   // ------------------------------------------------------------------
   // Input stage: clamp size, mask index, build raster answer
   // ------------------------------------------------------------------
   logic [LG_W-1:0]          lg_eff;
   logic [IN_EXT_W-1:0]      idx_ext;
   logic [CNT_W-1:0]         cnt_mask, idx_masked, idx_shifted;
   logic [MAX_LOG_SIZE-1:0]  side_mask, x_init, y_init;
   isoag_pkg::ctl_type       ctl_init;

   logic                     s1_valid_ff, s1_valid_in, s1_ready;
   logic [CNT_W-1:0]         s1_idx_ff;
   logic [MAX_LOG_SIZE-1:0]  s1_x_ff, s1_y_ff;
   isoag_pkg::ctl_type       s1_ctl_ff;

   always_comb begin
      lg_eff = LG_W'(log_size_ff);
      if (log_size_ff == 4'd0) begin
         lg_eff = LG_W'(1);
      end else if (lg_eff > LG_W'(MAX_LOG_SIZE)) begin
         lg_eff = LG_W'(MAX_LOG_SIZE);
      end
   end

   always_comb begin
      for (int i = 0; i < CNT_W; i++) begin
         cnt_mask[i] = (32'(i) < 32'({lg_eff, 1'b0}));
      end
      for (int i = 0; i < MAX_LOG_SIZE; i++) begin
         side_mask[i] = (32'(i) < 32'(lg_eff));
      end
   end

   assign idx_ext     = IN_EXT_W'(req_tdata[isoag_pkg::IDX_W-1:0]);
   assign idx_masked  = idx_ext[CNT_W-1:0] & cnt_mask;
   assign idx_shifted = idx_masked >> lg_eff;

   // Raster answer up front; curve modes start from zero and fill in bits
   always_comb begin
      if (scan_mode_ff == isoag_pkg::MODE_QUAD || scan_mode_ff == isoag_pkg::MODE_HILBERT) begin
         x_init = '0;
         y_init = '0;
      end else begin
         x_init = idx_masked[MAX_LOG_SIZE-1:0] & side_mask;
         y_init = idx_shifted[MAX_LOG_SIZE-1:0] & side_mask;
      end
      ctl_init.mode = scan_mode_ff;
      ctl_init.lg   = lg_eff;
      ctl_init.last = &(idx_masked | ~cnt_mask);
   end

   assign req_tready  = s1_ready;
   assign s1_valid_in = s1_ready ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && s1_ready) begin
         s1_idx_ff <= idx_masked;
         s1_x_ff   <= x_init;
         s1_y_ff   <= y_init;
         s1_ctl_ff <= ctl_init;
      end
   end

   // ------------------------------------------------------------------
   // Curve stages, up to LPS levels each, top level first
   // ------------------------------------------------------------------
   logic                     st_valid [0:NSTG];
   logic                     st_ready [0:NSTG];
   logic [CNT_W-1:0]         st_idx   [0:NSTG];
   logic [MAX_LOG_SIZE-1:0]  st_x     [0:NSTG];
   logic [MAX_LOG_SIZE-1:0]  st_y     [0:NSTG];
   isoag_pkg::orient_type    st_ori   [0:NSTG];
   isoag_pkg::ctl_type       st_ctl   [0:NSTG];

   assign st_valid[0] = s1_valid_ff;
   assign s1_ready    = !s1_valid_ff || st_ready[0];
   assign st_idx[0]   = s1_idx_ff;
   assign st_x[0]     = s1_x_ff;
   assign st_y[0]     = s1_y_ff;
   assign st_ori[0]   = START_ORI;
   assign st_ctl[0]   = s1_ctl_ff;

   for (genvar g = 0; g < NSTG; g++) begin : g_curve
      localparam int HI  = MAX_LOG_SIZE - 1 - g * LPS;
      localparam int NUM = (HI + 1 < LPS) ? HI + 1 : LPS;

      isoag_curve_stage #(
         .MAX_LOG_SIZE (MAX_LOG_SIZE),
         .HI_LEVEL     (HI),
         .NUM_LEVELS   (NUM)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[g]),
         .in_ready  (st_ready[g]),
         .in_idx    (st_idx[g]),
         .in_x      (st_x[g]),
         .in_y      (st_y[g]),
         .in_ori    (st_ori[g]),
         .in_ctl    (st_ctl[g]),
         .out_valid (st_valid[g+1]),
         .out_ready (st_ready[g+1]),
         .out_idx   (st_idx[g+1]),
         .out_x     (st_x[g+1]),
         .out_y     (st_y[g+1]),
         .out_ori   (st_ori[g+1]),
         .out_ctl   (st_ctl[g+1])
      );
   end

   // ------------------------------------------------------------------
   // Output register: form y*side+x and cut to field widths
   // ------------------------------------------------------------------
   logic                               out_valid_ff, out_valid_in, out_ready;
   logic [isoag_pkg::ADDR_W-1:0]       out_addr_ff;
   logic [isoag_pkg::COORD_W-1:0]      out_x_ff, out_y_ff;
   logic                               out_last_ff;
   logic [ADR_EXT_W-1:0]               addr_full;
   logic [CRD_EXT_W-1:0]               x_ext, y_ext;

   assign addr_full = (ADR_EXT_W'(st_y[NSTG]) << st_ctl[NSTG].lg) | ADR_EXT_W'(st_x[NSTG]);
   assign x_ext     = CRD_EXT_W'(st_x[NSTG]);
   assign y_ext     = CRD_EXT_W'(st_y[NSTG]);

   assign out_ready      = !out_valid_ff || rsp_tready;
   assign st_ready[NSTG] = out_ready;
   assign out_valid_in   = out_ready ? st_valid[NSTG] : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (st_valid[NSTG] && out_ready) begin
         out_addr_ff <= addr_full[isoag_pkg::ADDR_W-1:0];
         out_x_ff    <= x_ext[isoag_pkg::COORD_W-1:0];
         out_y_ff    <= y_ext[isoag_pkg::COORD_W-1:0];
         out_last_ff <= st_ctl[NSTG].last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_y_ff, out_x_ff, out_addr_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   // Input backpressure only arises behind a stalled, full output
   a_stall_origin: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled while output is free");

   // Effective size held in the pipe stays within 1..MAX_LOG_SIZE
   a_lg_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_ctl_ff.lg != '0 && s1_ctl_ff.lg <= LG_W'(MAX_LOG_SIZE)))
      else $error("effective log size out of range");

   // Coordinates leaving the walk lie inside the image
   a_coord_in_side: assert property (@(posedge clock) disable iff (reset)
      st_valid[NSTG] |-> ((st_x[NSTG] >> st_ctl[NSTG].lg) == '0 &&
                          (st_y[NSTG] >> st_ctl[NSTG].lg) == '0))
      else $error("coordinate beyond image side");
`endif

endmodule

`default_nettype wire

// ===== sim/image_scan_order_address_gen_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_scan_order_address_gen_tb: self-checking bench for the scan mapper
// Streams output positions under raster, Z-order and Hilbert scans at many
// image sizes, predicts the source pixel of each accepted position and
// compares every returned address, column, row and end flag in order.
// ----------------------------------------------------------------------------

module image_scan_order_address_gen_tb;
   import isoag_pkg::*;

   // Unused scan code, mapped like raster
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct {
      bit [ADDR_W-1:0]  address;
      bit [COORD_W-1:0] col;
      bit [COORD_W-1:0] row;
      bit               last;
   } pixel_type;

   // Tracks the register settings and the pixels still owed by the block
   class pixel_address_book;
      bit [1:0]    mode;
      bit [3:0]    log_size;
      pixel_type   pending_pixels[$];
      int unsigned errors;

      function new();
         mode     = MODE_RASTER;
         log_size = 4'd10;
         errors   = 0;
      endfunction

      // Clamp the side exponent into 1..10
      function int unsigned effective_log();
         if (log_size == 0) return 1;
         if (log_size > MAX_LOG_SIZE_DEF) return MAX_LOG_SIZE_DEF;
         return log_size;
      endfunction

      // One Hilbert level: quadrant position {row, col} and next orientation
      function void hilbert_cell(input orient_type o, input bit [1:0] q,
                                 output bit dx, output bit dy, output orient_type nxt);
         bit [1:0] path[4];
         case (o)
            OR_RIGHT: path = '{2'b00, 2'b01, 2'b11, 2'b10};
            OR_LEFT:  path = '{2'b11, 2'b10, 2'b00, 2'b01};
            OR_UP:    path = '{2'b11, 2'b01, 2'b00, 2'b10};
            default:  path = '{2'b00, 2'b10, 2'b11, 2'b01};
         endcase
         dx = path[q][0];
         dy = path[q][1];
         nxt = o;
         if (q == 2'd0) begin
            case (o)
               OR_RIGHT: nxt = OR_DOWN;
               OR_LEFT:  nxt = OR_UP;
               OR_UP:    nxt = OR_LEFT;
               default:  nxt = OR_RIGHT;
            endcase
         end else if (q == 2'd3) begin
            case (o)
               OR_RIGHT: nxt = OR_UP;
               OR_LEFT:  nxt = OR_DOWN;
               OR_UP:    nxt = OR_RIGHT;
               default:  nxt = OR_LEFT;
            endcase
         end
      endfunction

      // Map a scan position to its source pixel under the current settings
      function pixel_type map_index_to_pixel(input bit [IDX_W-1:0] index);
         int unsigned lg;
         int          lv;
         bit [IDX_W-1:0]   count_mask;
         bit [IDX_W-1:0]   side_mask;
         bit [IDX_W-1:0]   idx;
         bit [COORD_W-1:0] x;
         bit [COORD_W-1:0] y;
         bit [1:0]         q;
         bit               dx;
         bit               dy;
         orient_type       o;
         pixel_type        p;
         lg = effective_log();
         count_mask = IDX_W'((64'd1 << (2 * lg)) - 1);
         side_mask  = IDX_W'((64'd1 << lg) - 1);
         idx = index & count_mask;
         x = '0;
         y = '0;
         if (mode == MODE_QUAD) begin
            for (lv = lg - 1; lv >= 0; lv--) begin
               q = idx[2*lv +: 2];
               x[lv] = q[0];
               y[lv] = q[1];
            end
         end else if (mode == MODE_HILBERT) begin
            o = lg[0] ? OR_RIGHT : OR_DOWN;
            for (lv = lg - 1; lv >= 0; lv--) begin
               q = idx[2*lv +: 2];
               hilbert_cell(o, q, dx, dy, o);
               x[lv] = dx;
               y[lv] = dy;
            end
         end else begin
            x = COORD_W'(idx & side_mask);
            y = COORD_W'((idx >> lg) & side_mask);
         end
         p.address = (ADDR_W'(y) << lg) | ADDR_W'(x);
         p.col     = x;
         p.row     = y;
         p.last    = (idx == count_mask);
         return p;
      endfunction

      function void note_index(input bit [IDX_W-1:0] index);
         pending_pixels.push_back(map_index_to_pixel(index));
      endfunction

      // Compare one returned pixel with the oldest one owed
      function void check_pixel(input logic [RSP_TDATA_W-1:0] data, input logic last);
         pixel_type want;
         if (pending_pixels.size() == 0) begin
            $error("unexpected result transaction: tdata=%h tlast=%b", data, last);
            errors++;
            return;
         end
         want = pending_pixels.pop_front();
         if (data[19:0] !== want.address) begin
            $error("src_address: expected %0d, got %0d", want.address, data[19:0]);
            errors++;
         end
         if (data[29:20] !== want.col) begin
            $error("src_x: expected %0d, got %0d", want.col, data[29:20]);
            errors++;
         end
         if (data[39:30] !== want.row) begin
            $error("src_y: expected %0d, got %0d", want.row, data[39:30]);
            errors++;
         end
         if (last !== want.last) begin
            $error("is_last: expected %0d, got %0d", want.last, last);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_pixels.size();
      endfunction
   endclass

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;    // [19:0] out_index
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;           // [19:0] src_address, [29:20] src_x,
                                                // [39:30] src_y
   logic                   rsp_tlast;           // is_last
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   bit                     steady = 1'b0;
   bit [IDX_W-1:0]         index_queue[$];
   pixel_address_book      book = new();

   image_scan_order_address_gen DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Stall the result side now and then, except in the steady stretch
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 6);
   end

   // Check every result transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         book.check_pixel(rsp_tdata, rsp_tlast);
      end
   end

   // Register write: setup cycle, then access cycle until pready
   task automatic write_reg(input logic [REG_IDX_W-1:0] reg_idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_idx == REG_SCAN_MODE) book.mode = value[1:0];
      else book.log_size = value[3:0];
   endtask

   // Write both registers in random order, sometimes with junk upper bits
   task automatic configure(input bit [1:0] mode, input bit [3:0] lg);
      logic [31:0] mode_word;
      logic [31:0] size_word;
      mode_word = ($urandom_range(1) != 0) ? 32'($urandom) : 32'(mode);
      size_word = ($urandom_range(1) != 0) ? 32'($urandom) : 32'(lg);
      mode_word[1:0] = mode;
      size_word[3:0] = lg;
      if ($urandom_range(1) != 0) begin
         write_reg(REG_SCAN_MODE, mode_word);
         write_reg(REG_LOG_SIZE, size_word);
      end else begin
         write_reg(REG_LOG_SIZE, size_word);
         write_reg(REG_SCAN_MODE, mode_word);
      end
   endtask

   // Send all queued positions, idling now and then
   task automatic stream_indexes();
      bit [IDX_W-1:0] idx;
      while (index_queue.size() != 0) begin
         idx = index_queue.pop_front();
         while (!steady && $urandom_range(99) < 6) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {{(REQ_TDATA_W-IDX_W){1'b0}}, idx};
         do @(posedge clock); while (!req_tready);
         book.note_index(idx);
      end
      req_tvalid <= 1'b0;
   endtask

   // Wait until every owed pixel is back, plus the pipeline depth
   task automatic settle();
      while (book.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic play(input bit [1:0] mode, input bit [3:0] lg, input bit [IDX_W-1:0] list[$]);
      configure(mode, lg);
      index_queue = list;
      stream_indexes();
      settle();
   endtask

   // Random position: full-width noise, in-image, near the end, or the end
   function automatic bit [IDX_W-1:0] random_index(input int unsigned lg);
      longint span;
      int unsigned pick;
      span = longint'(1) << (2 * lg);
      pick = $urandom_range(99);
      if (pick < 40) return IDX_W'($urandom);
      if (pick < 80) return IDX_W'($urandom_range(span - 1));
      if (pick < 90) return IDX_W'(span - 1 - $urandom_range(3));
      return IDX_W'($urandom) | IDX_W'(span - 1);
   endfunction

   initial begin
      bit [1:0]    mode;
      bit [3:0]    lg;
      int unsigned count;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: raster at full size
      index_queue = '{20'h00000, 20'hFFFFF, 20'h55555, 20'hAAAAA, 20'h80000};
      stream_indexes();
      settle();

      play(MODE_QUAD, 4'd10, '{20'h00000, 20'hFFFFF, 20'h12345});
      // Even size starts the curve facing down
      play(MODE_HILBERT, 4'd10, '{20'h00000, 20'h00001, 20'h00002, 20'h00003, 20'hFFFFF});
      // Odd size starts facing right; upper index bits dropped
      play(MODE_HILBERT, 4'd3, '{20'h00000, 20'h0003F, 20'hFFF45});
      // Spare mode acts as raster; zero size acts as one
      play(MODE_SPARE, 4'd0, '{20'h00000, 20'h00003, 20'h00004});
      // Oversize clamps to the largest side
      play(MODE_QUAD, 4'd15, '{20'hFFFFF, 20'h00000});
      play(MODE_HILBERT, 4'd1, '{20'h00000, 20'h00001, 20'h00002, 20'hFFFF3});

      // Random phases with a long stretch free of idling on both sides
      for (int phase = 0; phase < 40; phase++) begin
         if (phase == 12) steady <= 1'b1;
         if (phase == 18) steady <= 1'b0;
         mode = ($urandom_range(99) < 10) ? MODE_SPARE : 2'($urandom_range(2));
         if ($urandom_range(99) < 80) lg = 4'($urandom_range(10, 1));
         else begin
            lg = 4'($urandom_range(5));
            if (lg != 0) lg = lg + 4'd10;
         end
         configure(mode, lg);
         count = $urandom_range(27, 15);
         repeat (count) index_queue.push_back(random_index(book.effective_log()));
         stream_indexes();
         settle();
      end

      settle();
      if (book.errors == 0 && book.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("FAILURE");
      $finish;
   end

endmodule
